// ===== rtl/evnt_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// evnt_pkg
// Shared widths, register map, reset values and defaults for the energy
// voice-activity detector with noise tracking.
// ============================================================================
package evnt_pkg;

    // Field widths
    localparam int POWER_W  = 31;
    localparam int FLEN_W   = 13;
    localparam int RATIO_W  = 16;
    localparam int HANG_W   = 8;
    localparam int KEEP_W   = 16;
    localparam int SNR_FRAC = 8;

    // APB port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_FRAME_LENGTH    = 3'd0;
    localparam logic [2:0] REG_THRESHOLD_POWER = 3'd1;
    localparam logic [2:0] REG_SNR_RATIO       = 3'd2;
    localparam logic [2:0] REG_HANGOVER_FRAMES = 3'd3;
    localparam logic [2:0] REG_SPEECH_KEEP     = 3'd4;
    localparam logic [2:0] REG_SILENCE_KEEP    = 3'd5;

    // Register reset values
    localparam logic [FLEN_W-1:0]  RST_FRAME_LENGTH    = 13'd640;
    localparam logic [POWER_W-1:0] RST_THRESHOLD_POWER = 31'd3395;
    localparam logic [RATIO_W-1:0] RST_SNR_RATIO       = 16'd768;
    localparam logic [HANG_W-1:0]  RST_HANGOVER_FRAMES = 8'd8;
    localparam logic [KEEP_W-1:0]  RST_SPEECH_KEEP     = 16'd65470;
    localparam logic [KEEP_W-1:0]  RST_SILENCE_KEEP    = 16'd62259;

    // Arithmetic constants
    localparam logic [POWER_W-1:0] POWER_MAX  = 31'h7FFF_FFFF;
    localparam logic [POWER_W-1:0] POWER_MIN  = 31'd1;
    localparam logic [KEEP_W:0]    KEEP_ONE   = 17'h1_0000;
    localparam logic [KEEP_W-1:0]  ROUND_HALF = 16'h8000;
    localparam int                 MIN_FRAME  = 4;

    // Parameter defaults
    localparam int DEF_SAMPLE_BITS       = 16;
    localparam int DEF_MAX_FRAME_SAMPLES = 4096;

endpackage

// ===== rtl/evnt_mul.sv =====
`timescale 1ns / 1ps
// ============================================================================
// evnt_mul
// Shared unsigned multiplier with a registered product. Used for the sample
// squares, the SNR product and both terms of the noise update.
// ============================================================================
module evnt_mul
    import evnt_pkg::*;
#(
    parameter int B_W = KEEP_W + 1
)
(
    input  logic                   clk,
    input  logic [POWER_W-1:0]     a,
    input  logic [B_W-1:0]         b,
    output logic [POWER_W+B_W-1:0] product
);

    logic [POWER_W+B_W-1:0] product_reg;

    // One multiply per cycle, result registered
    always_ff @(posedge clk)
    begin
        product_reg <= (POWER_W+B_W)'(a) * (POWER_W+B_W)'(b);
    end

    assign product = product_reg;

endmodule

// ===== rtl/evnt_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// evnt_div
// Restoring radix-2 divider, one quotient bit per cycle. Forms the frame mean
// power as energy sum over sample count.
// ============================================================================
module evnt_div
#(
    parameter int DIVIDEND_W = 44,
    parameter int DIVISOR_W  = 13
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [DIVIDEND_W-1:0] quot_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic                  fits;
    logic [DIVISOR_W:0]    rem_sub;

    // Trial subtract of the shifted partial remainder
    always_comb
    begin
        rem_shift = {rem_reg, quot_reg[DIVIDEND_W-1]};
        fits      = rem_shift >= {1'b0, dsr_reg};
        rem_sub   = rem_shift - {1'b0, dsr_reg};
    end

    // Control: step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == STEP_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            dsr_reg  <= divisor;
            quot_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            quot_reg <= {quot_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ===== rtl/energy_vad_noise_tracker_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// energy_vad_noise_tracker_unit
// Energy voice-activity detector with hangover and a tracked noise floor.
//
// Usage:
//   Samples enter on sample / sample_valid / sample_stall; one transfer per
//   sample. Squares are summed over frame_length samples (clamped to
//   MIN_FRAME..MAX_FRAME_SAMPLES). At each frame end one result (speech,
//   frame_power, noise_level) leaves on result_valid / result_stall; other
//   samples give no result. Each sample passes accept, square on the shared
//   multiplier and accumulate. A frame end adds the divider, one quotient
//   bit per cycle, then compare and noise update on the shared multiplier
//   (CMP, DEC, EMA1, EMA2, EMA3).
//   sample_stall is high while a sample or frame end is being processed.
//   A finished result waits in the output register; the next frame's
//   samples are still taken, and only a second frame end waits for it.
//   Reset loads the register defaults, clears the frame sum and hangover,
//   and sets the noise estimate to the default threshold.
//   Registers are on an APB port at byte address 4*index; write only while
//   the block is idle.
// ============================================================================
module energy_vad_noise_tracker_unit
    import evnt_pkg::*;
#(
    parameter int SAMPLE_BITS       = DEF_SAMPLE_BITS,
    parameter int MAX_FRAME_SAMPLES = DEF_MAX_FRAME_SAMPLES
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // Sample channel
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                         sample_valid,
    output logic                         sample_stall,
    // Result channel
    output logic                         speech,
    output logic [POWER_W-1:0]           frame_power,
    output logic [POWER_W-1:0]           noise_level,
    output logic                         result_valid,
    input  logic                         result_stall,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready
);

    localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
    localparam int CNT_W  = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int SUM_W  = SQ_W + CNT_W;
    localparam int MB_W   = (SAMPLE_BITS > KEEP_W + 1) ? SAMPLE_BITS : KEEP_W + 1;
    localparam int PROD_W = POWER_W + MB_W;
    localparam int LEN_W  = (CNT_W > FLEN_W) ? CNT_W : FLEN_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int RND_W  = ACC_W - KEEP_W;
    localparam int QX_W   = SUM_W + POWER_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQ   = 4'd1;
    localparam logic [3:0] S_ACC  = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_CMP  = 4'd4;
    localparam logic [3:0] S_DEC  = 4'd5;
    localparam logic [3:0] S_EMA1 = 4'd6;
    localparam logic [3:0] S_EMA2 = 4'd7;
    localparam logic [3:0] S_EMA3 = 4'd8;

    // Configuration registers
    logic [FLEN_W-1:0]  frame_length_reg;
    logic [POWER_W-1:0] threshold_reg;
    logic [RATIO_W-1:0] snr_ratio_reg;
    logic [HANG_W-1:0]  hangover_reg;
    logic [KEEP_W-1:0]  speech_keep_reg;
    logic [KEEP_W-1:0]  silence_keep_reg;

    // Control and tracker state
    logic [3:0]         state_reg;
    logic [3:0]         state_next;
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [POWER_W-1:0] noise_reg;
    logic [HANG_W-1:0]  hold_reg;
    logic               result_valid_reg;

    // Datapath registers
    logic [SAMPLE_BITS-1:0] mag_reg;
    logic [POWER_W-1:0]     power_reg;
    logic [KEEP_W-1:0]      keep_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic                   speech_reg;
    logic                   out_speech_reg;
    logic [POWER_W-1:0]     out_power_reg;
    logic [POWER_W-1:0]     out_noise_reg;

    // Combinational signals
    logic                   cfg_write;
    logic [2:0]             cfg_index;
    logic                   in_xfer;
    logic                   out_free;
    logic [SAMPLE_BITS-1:0] mag;
    logic [CNT_W-1:0]       cnt_next;
    logic [SUM_W-1:0]       sum_next;
    logic [LEN_W-1:0]       eff_len;
    logic                   frame_end;
    logic [POWER_W-1:0]     mul_a;
    logic [MB_W-1:0]        mul_b;
    logic [PROD_W-1:0]      prod;
    logic                   div_done;
    logic [SUM_W-1:0]       quot;
    logic [QX_W-1:0]        quot_ext;
    logic [POWER_W-1:0]     power_sat;
    logic [PROD_W-1:0]      power_sh;
    logic                   speech_raw;
    logic [KEEP_W:0]        inv_keep;
    logic [ACC_W-1:0]       ema_sum;
    logic [RND_W-1:0]       ema_r;
    logic [POWER_W-1:0]     ema_val;

    // APB decode
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];
    assign pready    = 1'b1;

    always_comb
    begin
        prdata = '0;
        unique case (cfg_index)
            REG_FRAME_LENGTH:    prdata = APB_DATA_W'(frame_length_reg);
            REG_THRESHOLD_POWER: prdata = APB_DATA_W'(threshold_reg);
            REG_SNR_RATIO:       prdata = APB_DATA_W'(snr_ratio_reg);
            REG_HANGOVER_FRAMES: prdata = APB_DATA_W'(hangover_reg);
            REG_SPEECH_KEEP:     prdata = APB_DATA_W'(speech_keep_reg);
            REG_SILENCE_KEEP:    prdata = APB_DATA_W'(silence_keep_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= RST_FRAME_LENGTH;
            threshold_reg    <= RST_THRESHOLD_POWER;
            snr_ratio_reg    <= RST_SNR_RATIO;
            hangover_reg     <= RST_HANGOVER_FRAMES;
            speech_keep_reg  <= RST_SPEECH_KEEP;
            silence_keep_reg <= RST_SILENCE_KEEP;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_LENGTH:    frame_length_reg <= pwdata[FLEN_W-1:0];
                REG_THRESHOLD_POWER: threshold_reg    <= pwdata[POWER_W-1:0];
                REG_SNR_RATIO:       snr_ratio_reg    <= pwdata[RATIO_W-1:0];
                REG_HANGOVER_FRAMES: hangover_reg     <= pwdata[HANG_W-1:0];
                REG_SPEECH_KEEP:     speech_keep_reg  <= pwdata[KEEP_W-1:0];
                REG_SILENCE_KEEP:    silence_keep_reg <= pwdata[KEEP_W-1:0];
                default:             ;
            endcase
        end
    end

    // Handshakes
    assign sample_stall = (state_reg != S_IDLE);
    assign in_xfer      = sample_valid && !sample_stall;
    assign out_free     = !result_valid_reg || !result_stall;

    // Sample magnitude, accumulation and frame-end check
    always_comb
    begin
        mag      = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
        cnt_next = count_reg + 1'b1;
        sum_next = sum_reg + SUM_W'(prod[SQ_W-1:0]);
        if (frame_length_reg < FLEN_W'(MIN_FRAME))
        begin
            eff_len = LEN_W'(MIN_FRAME);
        end
        else if (LEN_W'(frame_length_reg) > LEN_W'(MAX_FRAME_SAMPLES))
        begin
            eff_len = LEN_W'(MAX_FRAME_SAMPLES);
        end
        else
        begin
            eff_len = LEN_W'(frame_length_reg);
        end
        frame_end = LEN_W'(cnt_next) >= eff_len;
    end

    // Shared multiplier operand select
    assign inv_keep = KEEP_ONE - {1'b0, keep_reg};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SQ:
            begin
                mul_a = POWER_W'(mag_reg);
                mul_b = MB_W'(mag_reg);
            end
            S_CMP:
            begin
                mul_a = noise_reg;
                mul_b = MB_W'(snr_ratio_reg);
            end
            S_EMA1:
            begin
                mul_a = noise_reg;
                mul_b = MB_W'(keep_reg);
            end
            // new-power term, held while the result waits for the receiver
            S_EMA2, S_EMA3:
            begin
                mul_a = power_reg;
                mul_b = MB_W'(inv_keep);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    evnt_mul #(
        .B_W (MB_W)
    ) u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (prod)
    );

    evnt_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    ((state_reg == S_ACC) && frame_end),
        .dividend (sum_next),
        .divisor  (cnt_next),
        .done     (div_done),
        .quotient (quot)
    );

    // Power saturation, speech decision and noise update arithmetic
    always_comb
    begin
        quot_ext   = QX_W'(quot);
        power_sat  = (|quot_ext[QX_W-1:POWER_W]) ? POWER_MAX : quot_ext[POWER_W-1:0];
        power_sh   = PROD_W'({power_reg, {SNR_FRAC{1'b0}}});
        speech_raw = (power_reg >= threshold_reg) && (power_sh >= prod);
        ema_sum    = acc_reg + ACC_W'(prod) + ACC_W'(ROUND_HALF);
        ema_r      = ema_sum[ACC_W-1:KEEP_W];
        if (ema_r > RND_W'(POWER_MAX))
        begin
            ema_val = POWER_MAX;
        end
        else if (ema_r == '0)
        begin
            ema_val = POWER_MIN;
        end
        else
        begin
            ema_val = ema_r[POWER_W-1:0];
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_xfer) state_next = S_SQ;
            S_SQ:   state_next = S_ACC;
            S_ACC:  state_next = frame_end ? S_DIV : S_IDLE;
            S_DIV:  if (div_done) state_next = S_CMP;
            S_CMP:  state_next = S_DEC;
            S_DEC:  state_next = S_EMA1;
            S_EMA1: state_next = S_EMA2;
            S_EMA2: state_next = S_EMA3;
            S_EMA3: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state: sequencer, frame sum, noise estimate, hangover, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sum_reg          <= '0;
            count_reg        <= '0;
            noise_reg        <= RST_THRESHOLD_POWER;
            hold_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_ACC)
            begin
                sum_reg   <= frame_end ? '0 : sum_next;
                count_reg <= frame_end ? '0 : cnt_next;
            end
            if (state_reg == S_DEC)
            begin
                if (speech_raw)
                begin
                    hold_reg <= hangover_reg;
                end
                else if (hold_reg != '0)
                begin
                    hold_reg <= hold_reg - 1'b1;
                end
            end
            if ((state_reg == S_EMA3) && out_free)
            begin
                noise_reg        <= ema_val;
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mag_reg <= mag;
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            power_reg <= power_sat;
        end
        if (state_reg == S_DEC)
        begin
            keep_reg   <= speech_raw ? speech_keep_reg : silence_keep_reg;
            speech_reg <= speech_raw || (hold_reg != '0);
        end
        if (state_reg == S_EMA2)
        begin
            acc_reg <= ACC_W'(prod);
        end
        if ((state_reg == S_EMA3) && out_free)
        begin
            out_speech_reg <= speech_reg;
            out_power_reg  <= power_reg;
            out_noise_reg  <= ema_val;
        end
    end

    assign result_valid = result_valid_reg;
    assign speech       = out_speech_reg;
    assign frame_power  = out_power_reg;
    assign noise_level  = out_noise_reg;

endmodule
